>>> hdl/vsra_pkg.sv
// Shared types and codes for the variable-size ring allocator core.
// No dependencies; every other file of the block depends on this package.
package vsra_pkg;

   localparam int SIZE_BITS   = 16;
   localparam int ALIGN_BITS  = 4;
   localparam int STATUS_BITS = 3;
   // aligned size: 16-bit size plus up to 2^15 - 1 of rounding
   localparam int ASZ_BITS    = 17;

   localparam logic [SIZE_BITS-1:0]  BUFFER_SIZE_RESET    = 16'd4096;
   localparam logic [ALIGN_BITS-1:0] ALIGNMENT_LOG2_RESET = 4'd2;

   typedef enum logic [1:0] {
      REQ_ALLOCATE    = 2'd0,
      REQ_COMMIT      = 2'd1,
      REQ_BEGIN_READ  = 2'd2,
      REQ_FINISH_READ = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 3'd0,
      ST_BLOCKED   = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_BUSY      = 3'd3,
      ST_TOO_LARGE = 3'd4,
      ST_NO_COMMIT = 3'd5
   } status_type;

   typedef enum logic [0:0] {
      CSR_BUFFER_SIZE    = 1'b0,
      CSR_ALIGNMENT_LOG2 = 1'b1
   } csr_index_type;

   typedef struct packed {
      req_kind_type         kind;
      logic [SIZE_BITS-1:0] size;
   } req_item_type;

   typedef struct packed {
      status_type           status;
      logic [SIZE_BITS-1:0] offset;
      logic [SIZE_BITS-1:0] length;
   } rsp_item_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0]  buffer_size;
      logic [ALIGN_BITS-1:0] alignment_log2;
   } cfg_type;

   // handshake between the input register and the result register
   typedef struct packed {
      logic valid;    // input register holds a request
      logic advance;  // request moves into the result register this cycle
   } stage_ctl_type;

endpackage

>>> hdl/vsra_req_if.sv
// Request channel of the ring allocator: valid/ready plus request payload.
// Depends on vsra_pkg for field widths.
interface vsra_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           req_type;
   logic [vsra_pkg::SIZE_BITS-1:0]       size;

   modport source (output valid, output req_type, output size, input ready);
   modport sink   (input valid, input req_type, input size, output ready);
endinterface

>>> hdl/vsra_rsp_if.sv
// Result channel of the ring allocator: valid/ready plus result payload.
// Depends on vsra_pkg for field widths.
interface vsra_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [vsra_pkg::STATUS_BITS-1:0]     status;
   logic [vsra_pkg::SIZE_BITS-1:0]       offset;
   logic [vsra_pkg::SIZE_BITS-1:0]       length;

   modport source (output valid, output status, output offset, output length,
                   input ready);
   modport sink   (input valid, input status, input offset, input length,
                   output ready);
endinterface

>>> hdl/vsra_in_reg.sv
// Input register of the ring allocator: captures one request at a time.
// Depends on vsra_pkg.
module vsra_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  vsra_pkg::req_item_type in_item,
   input  logic                   advance,
   output logic                   held_valid,
   output vsra_pkg::req_item_type held_item
);
   import vsra_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;

   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            item_in = in_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;
endmodule

>>> hdl/vsra_ptr_unit.sv
// Ring pointer state and the single-pass request evaluation of the allocator.
// Depends on vsra_pkg; driven by the input register, feeds the result register.
module vsra_ptr_unit #(
   parameter int OFFSET_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  vsra_pkg::cfg_type      cfg,
   input  vsra_pkg::stage_ctl_type ctl,
   input  vsra_pkg::req_item_type req_item,
   output vsra_pkg::rsp_item_type rsp_item
);
   import vsra_pkg::*;

   // wide enough for an offset plus an aligned size without overflow
   localparam int CW = ((OFFSET_BITS > ASZ_BITS) ? OFFSET_BITS : ASZ_BITS) + 1;
   localparam logic [CW-1:0] OFF_MASK = CW'((CW'(1) << OFFSET_BITS) - CW'(1));

   logic [OFFSET_BITS-1:0] read_offset_ff,  read_offset_in;
   logic [OFFSET_BITS-1:0] write_offset_ff, write_offset_in;
   logic [OFFSET_BITS-1:0] open_start_ff,   open_start_in;
   logic [OFFSET_BITS-1:0] open_end_ff,     open_end_in;
   logic                   writing_ff,      writing_in;

   logic [ASZ_BITS-1:0] align_unit;
   logic [ASZ_BITS-1:0] align_sum;
   logic [ASZ_BITS-1:0] asz;
   logic [CW-1:0]       bs, asz_w, ro_w, wo_w, os_w, oe_w;
   logic [CW-1:0]       start_w, end_w, rd_w, rend_w, nr_w;
   rsp_item_type        result;

   assign align_unit = ASZ_BITS'(1) << cfg.alignment_log2;
   assign align_sum  = ASZ_BITS'(req_item.size) + align_unit - ASZ_BITS'(1);
   assign asz        = align_sum & ~(align_unit - ASZ_BITS'(1));

   assign bs    = CW'(cfg.buffer_size) & OFF_MASK;
   assign asz_w = CW'(asz);
   assign ro_w  = CW'(read_offset_ff);
   assign wo_w  = CW'(write_offset_ff);
   assign os_w  = CW'(open_start_ff);
   assign oe_w  = CW'(open_end_ff);

   always_comb begin
      read_offset_in  = read_offset_ff;
      write_offset_in = write_offset_ff;
      open_start_in   = open_start_ff;
      open_end_in     = open_end_ff;
      writing_in      = writing_ff;
      result.status   = ST_OK;
      result.offset   = '0;
      result.length   = '0;
      start_w = (wo_w < bs) ? wo_w : '0;
      end_w   = ((start_w + asz_w) > bs) ? bs : (start_w + asz_w);
      rd_w    = ro_w;
      rend_w  = bs;
      nr_w    = ro_w + asz_w;
      unique case (req_item.kind)
         REQ_ALLOCATE: begin
            priority if (writing_ff) begin
               result.status = ST_BUSY;
            end else if (asz_w >= bs) begin
               result.status = ST_TOO_LARGE;
            end else if (ro_w != wo_w && start_w <= ro_w && ro_w <= end_w) begin
               result.status = ST_BLOCKED;
            end else begin
               open_start_in = start_w[OFFSET_BITS-1:0];
               open_end_in   = end_w[OFFSET_BITS-1:0];
               writing_in    = 1'b1;
               result.offset = start_w[SIZE_BITS-1:0];
               result.length = SIZE_BITS'(end_w - start_w);
            end
         end
         REQ_COMMIT: begin
            if (!writing_ff) begin
               result.status = ST_NO_COMMIT;
            end else begin
               write_offset_in = open_end_ff;
               writing_in      = 1'b0;
               result.offset   = os_w[SIZE_BITS-1:0];
               result.length   = SIZE_BITS'(oe_w - os_w);
            end
         end
         REQ_BEGIN_READ: begin
            // wrap the read offset when it sits at or past the end and the write offset is behind it
            priority if (wo_w >= ro_w) begin
               rend_w = wo_w;
            end else if (ro_w >= bs) begin
               rd_w           = '0;
               read_offset_in = '0;
               rend_w         = wo_w;
            end else begin
               rend_w = bs;
            end
            if (rd_w < rend_w) begin
               result.offset = rd_w[SIZE_BITS-1:0];
               result.length = SIZE_BITS'(rend_w - rd_w);
            end else begin
               result.status = ST_EMPTY;
            end
         end
         REQ_FINISH_READ: begin
            // saturate at the end, never move backwards
            if (nr_w > bs) begin
               nr_w = (ro_w > bs) ? ro_w : bs;
            end
            read_offset_in = nr_w[OFFSET_BITS-1:0];
            result.offset  = nr_w[SIZE_BITS-1:0];
            result.length  = SIZE_BITS'(nr_w - ro_w);
         end
         default: begin
            result.status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_offset_ff  <= '0;
         write_offset_ff <= '0;
         open_start_ff   <= '0;
         open_end_ff     <= '0;
         writing_ff      <= 1'b0;
      end else if (ctl.advance) begin
         read_offset_ff  <= read_offset_in;
         write_offset_ff <= write_offset_in;
         open_start_ff   <= open_start_in;
         open_end_ff     <= open_end_in;
         writing_ff      <= writing_in;
      end
   end

   assign rsp_item = result;

`ifndef SYNTH
   a_alloc_opens: assert property (@(posedge clock) disable iff (reset)
      ctl.advance && req_item.kind == REQ_ALLOCATE && result.status == ST_OK
      |=> writing_ff)
      else $error("granted allocation did not open a region");

   a_commit_moves_write: assert property (@(posedge clock) disable iff (reset)
      ctl.advance && req_item.kind == REQ_COMMIT && result.status == ST_OK
      |=> !writing_ff && write_offset_ff == $past(open_end_ff))
      else $error("commit did not advance the write offset to the region end");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      ctl.advance && result.status != ST_OK
      |-> result.offset == '0 && result.length == '0)
      else $error("failed request carries a nonzero offset or length");

   a_finish_forward: assert property (@(posedge clock) disable iff (reset)
      ctl.advance && req_item.kind == REQ_FINISH_READ
      |=> read_offset_ff >= $past(read_offset_ff))
      else $error("finish read moved the read offset backwards");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !ctl.advance |=> $stable(writing_ff) && $stable(write_offset_ff)
                       && $stable(read_offset_ff))
      else $error("pointer state changed with no request advancing");
`endif
endmodule

>>> hdl/vsra_out_reg.sv
// Result register of the ring allocator: holds one result until taken.
// Depends on vsra_pkg.
module vsra_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  vsra_pkg::rsp_item_type load_item,
   output logic                   can_load,
   output logic                   out_valid,
   input  logic                   out_ready,
   output vsra_pkg::rsp_item_type out_item
);
   import vsra_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   assign can_load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (can_load) begin
         valid_in = load;
         if (load) begin
            item_in = load_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

>>> hdl/variable_size_ring_allocator_core.sv
// Pointer manager for a single-producer, single-consumer byte ring with
// variable-size, power-of-two aligned allocations. Every request (allocate,
// commit, begin read, finish read) yields exactly one result, in order.
// The block takes one request per cycle when the result side keeps up.
// An accepted request is held in the input register and evaluated by
// vsra_ptr_unit; its result is loaded into the result register, where the
// consumer takes it. The rate is set by the pointer state loop in
// vsra_ptr_unit, which evaluates a request and updates the four offsets and
// the open flag in a single pass. An allocate that would overrun the read
// offset returns blocked and changes nothing; retry it after the reader has
// moved on. Write buffer_size and alignment_log2 only while no request is in
// flight. Depends on vsra_pkg, vsra_req_if, vsra_rsp_if.
module variable_size_ring_allocator_core #(
   parameter int OFFSET_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   vsra_req_if.sink                               req_bus,
   vsra_rsp_if.source                             rsp_bus,
   input  logic                                   csr_write_enable,
   input  vsra_pkg::csr_index_type                csr_index,
   input  logic [vsra_pkg::SIZE_BITS-1:0]         csr_write_data
);
   import vsra_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   stage_ctl_type ctl;
   req_item_type  req_item, held_item;
   rsp_item_type  result_item, out_item;
   logic          out_can_load;
   logic          req_ready;
   logic          held_valid;
   logic          stage_advance;

   // configuration registers: take writes whenever enabled
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BUFFER_SIZE:    cfg_in.buffer_size    = csr_write_data;
            CSR_ALIGNMENT_LOG2: cfg_in.alignment_log2 = csr_write_data[ALIGN_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_size    <= BUFFER_SIZE_RESET;
         cfg_ff.alignment_log2 <= ALIGNMENT_LOG2_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // decode the request payload
   assign req_item = '{kind: req_kind_type'(req_bus.req_type), size: req_bus.size};

   // advance the held request whenever the result register can take it
   assign stage_advance = held_valid && out_can_load;
   assign ctl = '{valid: held_valid, advance: stage_advance};

   vsra_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_bus.valid),
      .in_ready   (req_ready),
      .in_item    (req_item),
      .advance    (stage_advance),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   assign req_bus.ready = req_ready;

   vsra_ptr_unit #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_ptr_unit (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .ctl      (ctl),
      .req_item (held_item),
      .rsp_item (result_item)
   );

   // hold the result until the consumer takes it
   vsra_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (held_valid),
      .load_item (result_item),
      .can_load  (out_can_load),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_item  (out_item)
   );

   assign rsp_bus.status = out_item.status;
   assign rsp_bus.offset = out_item.offset;
   assign rsp_bus.length = out_item.length;
endmodule
